// ===== rtl/sm83_alu_flag_unit_defines.svh =====
// Assertion helpers shared by the execution unit RTL.
`ifndef SM83_ALU_FLAG_UNIT_DEFINES_SVH
`define SM83_ALU_FLAG_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SM83_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SM83_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sm83_pkg.sv =====
`default_nettype none

package sm83_pkg;

  localparam int KIND_W  = 5;
  localparam int WORD_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int BIDX_W  = 3;
  localparam int FLAGS_W = 4;

  // Flag positions inside the four-bit flag word.
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
  localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
  localparam logic [8:0] DAA_HIGH_LIM = 9'h09F;
  localparam logic [3:0] BCD_DIGIT_MAX = 4'd9;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD  = 5'd0,  OP_ADC  = 5'd1,  OP_SUB  = 5'd2,  OP_SBC  = 5'd3,
    OP_AND  = 5'd4,  OP_XOR  = 5'd5,  OP_OR   = 5'd6,  OP_CP   = 5'd7,
    OP_RLC  = 5'd8,  OP_RRC  = 5'd9,  OP_RL   = 5'd10, OP_RR   = 5'd11,
    OP_SLA  = 5'd12, OP_SRA  = 5'd13, OP_SWAP = 5'd14, OP_SRL  = 5'd15,
    OP_RLCA = 5'd16, OP_RRCA = 5'd17, OP_RLA  = 5'd18, OP_RRA  = 5'd19,
    OP_DAA  = 5'd20, OP_CPL  = 5'd21, OP_SCF  = 5'd22, OP_CCF  = 5'd23,
    OP_INC  = 5'd24, OP_DEC  = 5'd25, OP_BIT  = 5'd26, OP_RES  = 5'd27,
    OP_SET  = 5'd28, OP_ADDHL = 5'd29, OP_ADDSP = 5'd30
  } kind_t;

  // Shift selector, taken from the low three bits of the operation code.
  typedef enum logic [2:0] {
    SH_RLC = 3'd0, SH_RRC = 3'd1, SH_RL = 3'd2, SH_RR = 3'd3,
    SH_SLA = 3'd4, SH_SRA = 3'd5, SH_SWAP = 3'd6, SH_SRL = 3'd7
  } shift_t;

endpackage

`default_nettype wire

// ===== rtl/sm83_alu_flag_unit.sv =====
`default_nettype none

// SM83 execution unit: each request carries an operation code, two operands,
// a bit number and the incoming Z/N/H/C flags, and produces one result request
// with the operation's value and the new flags. It covers the 8-bit ALU group,
// the CB shifts and rotates, the accumulator rotates, DAA, CPL, SCF, CCF,
// INC/DEC, BIT/RES/SET, ADD HL,rr and ADD SP,e8; unused code 31 passes the
// operand and flags through. The unit takes one request every cycle while
// it is not stalled; each accepted request waits in the input register, then
// the adders and flag logic settle into the result register. Both channels
// use valid/stall; a stalled result holds while the input register still
// takes a new request, and the input side stalls only when both registers
// are full.

`include "sm83_alu_flag_unit_defines.svh"

module sm83_alu_flag_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sm83_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [sm83_pkg::WORD_W-1:0]   in_first,
  input  wire logic [sm83_pkg::WORD_W-1:0]   in_second,
  input  wire logic [sm83_pkg::BIDX_W-1:0]   in_bit_index,
  input  wire logic [sm83_pkg::FLAGS_W-1:0]  in_flags_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sm83_pkg::WORD_W-1:0]        out_result,
  output logic [sm83_pkg::FLAGS_W-1:0]       out_flags_out
);
  import sm83_pkg::*;

  // Input register stage.
  logic                s1_valid_r;
  logic [KIND_W-1:0]   s1_kind_r;
  logic [WORD_W-1:0]   s1_first_r;
  logic [WORD_W-1:0]   s1_second_r;
  logic [BIDX_W-1:0]   s1_bit_r;
  logic [FLAGS_W-1:0]  s1_flags_r;

  // Result register stage.
  logic                s2_valid_r;
  logic [WORD_W-1:0]   s2_result_r;
  logic [FLAGS_W-1:0]  s2_flags_r;
  logic [WORD_W-1:0]   s2_result_nxt;
  logic [FLAGS_W-1:0]  s2_flags_nxt;

  logic s2_adv;
  logic s1_adv;

  // The result register can load when it is empty or being drained; the
  // input register can load when it is empty or moving forward.
  assign s2_adv   = !s2_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_kind_r   <= in_kind;
      s1_first_r  <= in_first;
      s1_second_r <= in_second;
      s1_bit_r    <= in_bit_index;
      s1_flags_r  <= in_flags_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      s2_result_r <= s2_result_nxt;
      s2_flags_r  <= s2_flags_nxt;
    end
  end

  assign out_valid     = s2_valid_r;
  assign out_result    = s2_result_r;
  assign out_flags_out = s2_flags_r;

  // Execution logic between the two register stages.
  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] v;
  logic              cy;
  logic              ci;
  logic [8:0]        sum8;
  logic [4:0]        sum4;
  logic [8:0]        dif8;
  logic [4:0]        dif4;
  logic [BYTE_W-1:0] logic_r;
  logic [BYTE_W-1:0] sh_r;
  logic              sh_c;
  logic [8:0]        daa_r;
  logic [BYTE_W-1:0] inc_r;
  logic [BYTE_W-1:0] dec_r;
  logic [BYTE_W-1:0] bmask;
  logic [WORD_W:0]   sum16;
  logic [12:0]       sum12;
  logic [WORD_W-1:0] sp_sum;
  logic [8:0]        sp_lo8;
  logic [4:0]        sp_lo4;

  always_comb begin
    a  = s1_first_r[BYTE_W-1:0];
    v  = s1_second_r[BYTE_W-1:0];
    cy = s1_flags_r[FLAG_C];
    ci = cy && (s1_kind_r == OP_ADC || s1_kind_r == OP_SBC);

    sum8 = {1'b0, a} + {1'b0, v} + {8'd0, ci};
    sum4 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, ci};
    // Borrows show up as the top bit of the widened differences.
    dif8 = {1'b0, a} - {1'b0, v} - {8'd0, ci};
    dif4 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, ci};

    case (s1_kind_r[1:0])
      2'd0:    logic_r = a & v;
      2'd1:    logic_r = a ^ v;
      default: logic_r = a | v;
    endcase

    case (shift_t'(s1_kind_r[2:0]))
      SH_RLC:  begin sh_c = a[7]; sh_r = {a[6:0], a[7]}; end
      SH_RRC:  begin sh_c = a[0]; sh_r = {a[0], a[7:1]}; end
      SH_RL:   begin sh_c = a[7]; sh_r = {a[6:0], cy}; end
      SH_RR:   begin sh_c = a[0]; sh_r = {cy, a[7:1]}; end
      SH_SLA:  begin sh_c = a[7]; sh_r = {a[6:0], 1'b0}; end
      SH_SRA:  begin sh_c = a[0]; sh_r = {a[7], a[7:1]}; end
      SH_SWAP: begin sh_c = 1'b0; sh_r = {a[3:0], a[7:4]}; end
      default: begin sh_c = a[0]; sh_r = {1'b0, a[7:1]}; end
    endcase

    // Decimal adjust: after an addition the low then high digit is fixed up
    // upward; after a subtraction the flags alone select the corrections.
    daa_r = {1'b0, a};
    if (!s1_flags_r[FLAG_N]) begin
      if (s1_flags_r[FLAG_H] || (a[3:0] > BCD_DIGIT_MAX)) begin
        daa_r = daa_r + {1'b0, DAA_LOW_ADJ};
      end
      if (cy || (daa_r > DAA_HIGH_LIM)) begin
        daa_r = daa_r + {1'b0, DAA_HIGH_ADJ};
      end
    end else begin
      if (s1_flags_r[FLAG_H]) begin
        daa_r = {1'b0, daa_r[7:0] - DAA_LOW_ADJ};
      end
      if (cy) begin
        daa_r = daa_r - {1'b0, DAA_HIGH_ADJ};
      end
    end

    inc_r = a + 8'd1;
    dec_r = a - 8'd1;
    bmask = 8'd1 << s1_bit_r;

    sum16  = {1'b0, s1_first_r} + {1'b0, s1_second_r};
    sum12  = {1'b0, s1_first_r[11:0]} + {1'b0, s1_second_r[11:0]};
    sp_sum = s1_first_r + {{BYTE_W{v[7]}}, v};
    sp_lo8 = {1'b0, s1_first_r[7:0]} + {1'b0, v};
    sp_lo4 = {1'b0, s1_first_r[3:0]} + {1'b0, v[3:0]};
  end

  always_comb begin
    s2_result_nxt = s1_first_r;
    s2_flags_nxt  = s1_flags_r;
    unique case (s1_kind_r) inside
      OP_ADD, OP_ADC: begin
        s2_result_nxt = {8'd0, sum8[7:0]};
        s2_flags_nxt  = {sum8[7:0] == 8'd0, 1'b0, sum4[4], sum8[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // Compare sets the flags of a subtraction but keeps the operand.
        if (s1_kind_r != OP_CP) begin
          s2_result_nxt = {8'd0, dif8[7:0]};
        end
        s2_flags_nxt = {dif8[7:0] == 8'd0, 1'b1, dif4[4], dif8[8]};
      end
      OP_AND, OP_XOR, OP_OR: begin
        s2_result_nxt = {8'd0, logic_r};
        s2_flags_nxt  = {logic_r == 8'd0, 1'b0, s1_kind_r == OP_AND, 1'b0};
      end
      [OP_RLC:OP_SRL]: begin
        s2_result_nxt = {8'd0, sh_r};
        s2_flags_nxt  = {sh_r == 8'd0, 2'b00, sh_c};
      end
      [OP_RLCA:OP_RRA]: begin
        // Accumulator rotates always clear zero.
        s2_result_nxt = {8'd0, sh_r};
        s2_flags_nxt  = {3'b000, sh_c};
      end
      OP_DAA: begin
        s2_result_nxt = {8'd0, daa_r[7:0]};
        s2_flags_nxt  = {daa_r[7:0] == 8'd0, s1_flags_r[FLAG_N], 1'b0, cy || daa_r[8]};
      end
      OP_CPL: begin
        s2_result_nxt = {8'd0, ~a};
        s2_flags_nxt  = {s1_flags_r[FLAG_Z], 2'b11, cy};
      end
      OP_SCF: begin
        s2_flags_nxt = {s1_flags_r[FLAG_Z], 2'b00, 1'b1};
      end
      OP_CCF: begin
        s2_flags_nxt = {s1_flags_r[FLAG_Z], 2'b00, !cy};
      end
      OP_INC: begin
        s2_result_nxt = {8'd0, inc_r};
        s2_flags_nxt  = {inc_r == 8'd0, 1'b0, a[3:0] == 4'hF, cy};
      end
      OP_DEC: begin
        s2_result_nxt = {8'd0, dec_r};
        s2_flags_nxt  = {dec_r == 8'd0, 1'b1, a[3:0] == 4'h0, cy};
      end
      OP_BIT: begin
        s2_flags_nxt = {(a & bmask) == 8'd0, 2'b01, cy};
      end
      OP_RES: begin
        s2_result_nxt = {8'd0, a & ~bmask};
      end
      OP_SET: begin
        s2_result_nxt = {8'd0, a | bmask};
      end
      OP_ADDHL: begin
        s2_result_nxt = sum16[WORD_W-1:0];
        s2_flags_nxt  = {s1_flags_r[FLAG_Z], 1'b0, sum12[12], sum16[WORD_W]};
      end
      OP_ADDSP: begin
        // Flags come from the unsigned low-byte addition.
        s2_result_nxt = sp_sum;
        s2_flags_nxt  = {2'b00, sp_lo4[4], sp_lo8[8]};
      end
      default: begin
        s2_result_nxt = s1_first_r;
        s2_flags_nxt  = s1_flags_r;
      end
    endcase
  end

  // An accepted request always lands in the input register.
  `SM83_ASSERT_NEXT(a_accept_loads, in_valid && !in_stall, s1_valid_r,
                    "accepted request did not reach the input register")
  // A held input register keeps its request intact.
  `SM83_ASSERT_NEXT(a_s1_holds, s1_valid_r && !s2_adv,
                    s1_valid_r && $stable(s1_kind_r) && $stable(s1_first_r),
                    "input register changed while blocked")
  // Back-pressure only when both stages are full and the sink stalls.
  `SM83_ASSERT_NOW(a_stall_cause, in_stall, s1_valid_r && s2_valid_r && out_stall,
                   "input stalled with room in the pipeline")
  // A request moving forward shows up as a result next cycle.
  `SM83_ASSERT_NEXT(a_s1_to_out, s1_valid_r && s2_adv, out_valid,
                    "request in the input register was lost")

endmodule

`default_nettype wire
